### rtl/task_admission_slot_table_unit_defines.svh
// Assertion macros used by the checker file of the slot table unit.
`ifndef TASK_ADMISSION_SLOT_TABLE_UNIT_DEFINES_SVH
`define TASK_ADMISSION_SLOT_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TAST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot table check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TAST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot table check failed");

`endif

### rtl/tast_pkg.sv
// Package: constants, codes and controller/datapath link types of the slot table unit.
package tast_pkg;

   localparam int SLOTS      = 10;
   localparam int TYPES      = 2;
   localparam int EVENTS     = 10;
   localparam int TABLE_SIZE = SLOTS * TYPES;

   localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int OFF_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TY_W  = (TYPES > 1) ? $clog2(TYPES) : 1;

   localparam logic [31:0] WINDOW_RESET  = 32'd2000000000;
   localparam logic [31:0] TIMEOUT_RESET = 32'd2000000000;
   localparam logic [15:0] DELAY_RESET   = 16'd1000;

   localparam logic [7:0] EV_APP_BEGIN = 8'd1;
   localparam logic [7:0] EV_APP_END   = 8'd2;

   localparam logic [1:0] CSR_WINDOW  = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_DELAY   = 2'd2;

   typedef enum logic [1:0] {
      FUNC_EVENT   = 2'd0,
      FUNC_REQUEST = 2'd1,
      FUNC_START   = 2'd2,
      FUNC_FINISH  = 2'd3
   } func_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic step;
   } tast_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
   } tast_sts_type;

endpackage

### rtl/task_admission_slot_table_unit.sv
// Top level: background task admission controller with a per-type slot table.
//
//  channel   ports                                  beat taken when
//  --------  -------------------------------------  --------------------------
//  request   start/busy, req_func..req_task_id      start high, busy low
//  response  rsp_valid, rsp_status/delay_ms/stored  rsp_valid high (one cycle)
//  csr       csr_valid/ready, csr_index, csr_wdata  csr_valid and csr_ready
//
// One item at a time: the next item is accepted in idle, after the result beat
// of the last. The scan visits n slots, one per cycle through a single expiry
// comparator: 0 for a system event or a request held by a recent app start,
// up to SLOTS for start or finish, up to TYPES*SLOTS for a request.
// Synchronous reset clears the controller, the occupancy bits and the
// app-start time and loads the config defaults; no clearing pass is needed.
// The response beat cannot be stalled; csr writes are taken at any time.
module task_admission_slot_table_unit import tast_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [62:0]        req_now,
   input  logic [7:0]         req_event_code,
   input  logic [2:0]         req_task_type,
   input  logic signed [31:0] req_task_id,
   output logic               rsp_valid,
   output logic               rsp_status,
   output logic [15:0]        rsp_delay_ms,
   output logic               rsp_stored,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   tast_cmd_type cmd;
   tast_sts_type sts;

   // config writes never conflict with the scan, so take every beat
   assign csr_ready = 1'b1;

   // sequence each item: load, decode, scan slots, present the result beat
   tast_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // hold the item, the slot table and the result registers
   tast_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_now        (req_now),
      .req_event_code (req_event_code),
      .req_task_type  (req_task_type),
      .req_task_id    (req_task_id),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_status     (rsp_status),
      .rsp_delay_ms   (rsp_delay_ms),
      .rsp_stored     (rsp_stored)
   );

endmodule

### rtl/tast_datapath.sv
// Datapath: item and result registers, config registers, slot table and scan logic.
module tast_datapath import tast_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  tast_cmd_type       cmd,
   output tast_sts_type       sts,
   input  logic [1:0]         req_func,
   input  logic [62:0]        req_now,
   input  logic [7:0]         req_event_code,
   input  logic [2:0]         req_task_type,
   input  logic signed [31:0] req_task_id,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic               rsp_status,
   output logic [15:0]        rsp_delay_ms,
   output logic               rsp_stored
);

   func_type           func_ff, func_in;
   logic [62:0]        now_ff, now_in;
   logic [7:0]         code_ff, code_in;
   logic [2:0]         type_ff, type_in;
   logic signed [31:0] id_ff, id_in;

   logic               status_ff, status_in;
   logic [15:0]        delay_ff, delay_in;
   logic               stored_ff, stored_in;

   logic [31:0]        window_ff, window_in;
   logic [31:0]        timeout_ff, timeout_in;
   logic [15:0]        delay_value_ff, delay_value_in;

   logic [62:0]        app_start_ff, app_start_in;
   logic [TABLE_SIZE-1:0] occ_ff, occ_in;
   logic signed [31:0] slot_id_ff [TABLE_SIZE];
   logic [62:0]        slot_time_ff [TABLE_SIZE];
   logic               slot_wr;

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [TY_W-1:0]    scan_type_ff, scan_type_in;
   logic               any_free_ff, any_free_in;

   logic [63:0]        win_diff, exp_diff;
   logic               in_window, expired, cur_occ, slot_free;
   logic               event_bad, type_bad, off_last, type_last;
   logic [IDX_W-1:0]   type_base;
   logic               scan_done;

   assign win_diff  = {1'b0, now_ff} - {1'b0, app_start_ff};
   assign in_window = $signed(win_diff) < $signed({32'd0, window_ff});
   assign exp_diff  = {1'b0, now_ff} - {1'b0, slot_time_ff[idx_ff]};
   assign expired   = $signed(exp_diff) >= $signed({32'd0, timeout_ff});
   assign cur_occ   = occ_ff[idx_ff];
   assign slot_free = !cur_occ || expired;
   assign event_bad = int'(code_ff) >= EVENTS;
   assign type_bad  = int'(type_ff) >= TYPES;
   assign off_last  = off_ff == OFF_W'(SLOTS - 1);
   assign type_last = scan_type_ff == TY_W'(TYPES - 1);
   assign type_base = IDX_W'(int'(type_ff) * SLOTS);

   always_comb begin
      func_in        = func_ff;
      now_in         = now_ff;
      code_in        = code_ff;
      type_in        = type_ff;
      id_in          = id_ff;
      status_in      = status_ff;
      delay_in       = delay_ff;
      stored_in      = stored_ff;
      window_in      = window_ff;
      timeout_in     = timeout_ff;
      delay_value_in = delay_value_ff;
      app_start_in   = app_start_ff;
      occ_in         = occ_ff;
      idx_in         = idx_ff;
      off_in         = off_ff;
      scan_type_in   = scan_type_ff;
      any_free_in    = any_free_ff;
      slot_wr        = 1'b0;
      scan_done      = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW:  window_in      = csr_wdata;
            CSR_TIMEOUT: timeout_in     = csr_wdata;
            CSR_DELAY:   delay_value_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         func_in   = func_type'(req_func);
         now_in    = req_now;
         code_in   = req_event_code;
         type_in   = req_task_type;
         id_in     = req_task_id;
         status_in = 1'b0;
         delay_in  = '0;
         stored_in = 1'b0;
      end

      if (cmd.decode) begin
         idx_in       = '0;
         off_in       = '0;
         scan_type_in = '0;
         any_free_in  = 1'b0;
         case (func_ff)
            FUNC_EVENT: begin
               if (event_bad) begin
                  status_in = 1'b1;
               end else if (code_ff == EV_APP_BEGIN) begin
                  app_start_in = now_ff;
               end else if (code_ff == EV_APP_END) begin
                  app_start_in = '0;
               end
            end
            FUNC_REQUEST: begin
               if (in_window) begin
                  delay_in = delay_value_ff;
               end
            end
            FUNC_START, FUNC_FINISH: begin
               status_in = type_bad;
               idx_in    = type_base;
            end
            default: ;
         endcase
      end

      if (cmd.step) begin
         idx_in = idx_ff + IDX_W'(1);
         off_in = off_ff + OFF_W'(1);
         case (func_ff)
            FUNC_REQUEST: begin
               // vacate an expired slot, then count it as free
               if (cur_occ && expired) begin
                  occ_in[idx_ff] = 1'b0;
               end
               if (off_last) begin
                  if (!(any_free_ff || slot_free)) begin
                     delay_in  = delay_value_ff;
                     scan_done = 1'b1;
                  end else if (type_last) begin
                     scan_done = 1'b1;
                  end else begin
                     off_in       = '0;
                     scan_type_in = scan_type_ff + TY_W'(1);
                     any_free_in  = 1'b0;
                  end
               end else begin
                  any_free_in = any_free_ff || slot_free;
               end
            end
            FUNC_START: begin
               if (slot_free) begin
                  occ_in[idx_ff] = 1'b1;
                  slot_wr        = 1'b1;
                  stored_in      = 1'b1;
                  scan_done      = 1'b1;
               end else begin
                  scan_done = off_last;
               end
            end
            FUNC_FINISH: begin
               if (cur_occ && (slot_id_ff[idx_ff] == id_ff)) begin
                  occ_in[idx_ff] = 1'b0;
                  scan_done      = 1'b1;
               end else begin
                  scan_done = off_last;
               end
            end
            default: scan_done = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= WINDOW_RESET;
         timeout_ff     <= TIMEOUT_RESET;
         delay_value_ff <= DELAY_RESET;
         app_start_ff   <= '0;
         occ_ff         <= '0;
      end else begin
         window_ff      <= window_in;
         timeout_ff     <= timeout_in;
         delay_value_ff <= delay_value_in;
         app_start_ff   <= app_start_in;
         occ_ff         <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      now_ff       <= now_in;
      code_ff      <= code_in;
      type_ff      <= type_in;
      id_ff        <= id_in;
      status_ff    <= status_in;
      delay_ff     <= delay_in;
      stored_ff    <= stored_in;
      idx_ff       <= idx_in;
      off_ff       <= off_in;
      scan_type_ff <= scan_type_in;
      any_free_ff  <= any_free_in;
      if (slot_wr) begin
         slot_id_ff[idx_ff]   <= id_ff;
         slot_time_ff[idx_ff] <= now_ff;
      end
   end

   assign sts.need_scan = ((func_ff == FUNC_REQUEST) && !in_window) ||
                          (((func_ff == FUNC_START) || (func_ff == FUNC_FINISH)) && !type_bad);
   assign sts.scan_done = scan_done;

   assign rsp_status   = status_ff;
   assign rsp_delay_ms = delay_ff;
   assign rsp_stored   = stored_ff;

endmodule

### rtl/tast_controller.sv
// Controller: sequences load, decode, slot scan and result beat.
module tast_controller import tast_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  tast_sts_type sts,
   output tast_cmd_type cmd,
   output logic         busy,
   output logic         rsp_valid
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECODE = 4'b0010,
      S_SCAN   = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.decode = 1'b0;
      cmd.step   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = sts.need_scan ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

endmodule

### rtl/tast_checker.sv
// Checker: port-level properties of the slot table unit, bound to the top level.
`include "task_admission_slot_table_unit_defines.svh"

module tast_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_status,
   input logic [15:0] rsp_delay_ms,
   input logic        rsp_stored
);

   // response beat that carries a nonzero delay
   logic delay_beat;

   assign delay_beat = rsp_valid && (rsp_delay_ms != 16'd0);

   `TAST_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `TAST_ASSERT_NOW(a_rsp_in_busy, clock, reset, rsp_valid, busy)
   `TAST_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `TAST_ASSERT_NOW(a_delay_req_only, clock, reset, delay_beat, !rsp_status && !rsp_stored)

endmodule

bind task_admission_slot_table_unit tast_checker u_tast_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_delay_ms (rsp_delay_ms),
   .rsp_stored   (rsp_stored)
);
